### src/ttd_pkg.sv
package ttd_pkg;

   // defaults for the top-level parameters
   localparam int TICKS_PER_TENTH_DEF = 25;
   localparam int TICK_WIDTH_DEF      = 32;

   // fixed field widths
   localparam int TICK_PORT_W  = 32;
   localparam int CHAR_W       = 8;
   localparam int RESULT_COUNT = 12;

   // quotient bits resolved per divider stage
   localparam int DIV_BITS_PER_STAGE = 4;

   // mixed radix above the tenth
   localparam int TENTHS_PER_MINUTE = 600;
   localparam int MINUTES_PER_HOUR  = 60;
   localparam int HOUR_WRAP         = 1000;

   localparam int TENTHS_REM_W = $clog2(TENTHS_PER_MINUTE + 1);
   localparam int MINUTE_REM_W = $clog2(MINUTES_PER_HOUR + 1);
   localparam int HOUR_REM_W   = $clog2(HOUR_WRAP + 1);

   // small decimal split by reciprocal multiply, exact below 1029
   localparam int DIGIT_W     = 4;
   localparam int DIV10_IN_W  = 10;
   localparam int DIV10_OUT_W = 7;
   localparam int DIV10_MULT  = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int DIV10_P_W   = DIV10_IN_W + 8;

   // characters
   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] ASCII_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] ASCII_PERIOD  = 8'h2E;
   localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'h0A;

   // decimal digits of one display, most significant first
   typedef struct packed {
      logic [DIGIT_W-1:0] h2;
      logic [DIGIT_W-1:0] h1;
      logic [DIGIT_W-1:0] h0;
      logic [DIGIT_W-1:0] m1;
      logic [DIGIT_W-1:0] m0;
      logic [DIGIT_W-1:0] s1;
      logic [DIGIT_W-1:0] s0;
      logic [DIGIT_W-1:0] t;
   } digits_type;

   function automatic logic [DIV10_OUT_W-1:0] div10(input logic [DIV10_IN_W-1:0] x);
      logic [DIV10_P_W-1:0] p;
      p = DIV10_P_W'(x) * DIV10_P_W'(DIV10_MULT);
      return DIV10_OUT_W'(p >> DIV10_SHIFT);
   endfunction

   function automatic logic [DIGIT_W-1:0] rem10(input logic [DIV10_IN_W-1:0] x,
                                                input logic [DIV10_OUT_W-1:0] q);
      logic [DIV10_IN_W-1:0] r;
      r = x - DIV10_IN_W'(q) * DIV10_IN_W'(10);
      return r[DIGIT_W-1:0];
   endfunction

endpackage

### src/ttd_cdiv.sv
module ttd_cdiv
   import ttd_pkg::*;
#(
   parameter int WIDTH   = TICK_WIDTH_DEF,
   parameter int DIVISOR = TICKS_PER_TENTH_DEF,
   parameter int SIDE_W  = 1,
   localparam int REM_W  = $clog2(DIVISOR + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [WIDTH-1:0]  in_num,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [WIDTH-1:0]  out_quo,
   output logic [REM_W-1:0]  out_rem,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STAGES = (WIDTH + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
   localparam int PAD_W  = STAGES * DIV_BITS_PER_STAGE;
   localparam logic [REM_W:0] DIV_K = (REM_W + 1)'(DIVISOR);

   // work word: numerator bits leave at the top, quotient bits enter at the bottom
   logic [PAD_W-1:0]  work_ff [STAGES];
   logic [PAD_W-1:0]  work_in [STAGES];
   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [REM_W-1:0]  rem_in  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_src;
   logic [STAGES-1:0] rdy;

   // restoring division, a few quotient bits per stage
   function automatic logic [PAD_W+REM_W-1:0] div_step(input logic [PAD_W-1:0] w_i,
                                                       input logic [REM_W-1:0] r_i);
      logic [PAD_W-1:0] w;
      logic [REM_W-1:0] r;
      logic [REM_W:0]   sh;
      w = w_i;
      r = r_i;
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
         sh = {r, w[PAD_W-1]};
         w  = {w[PAD_W-2:0], 1'b0};
         if (sh >= DIV_K) begin
            sh   = sh - DIV_K;
            w[0] = 1'b1;
         end
         r = sh[REM_W-1:0];
      end
      return {w, r};
   endfunction

   // stage inputs and next values
   always_comb begin
      logic [PAD_W-1:0] pre_work;
      logic [REM_W-1:0] pre_rem;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            pre_work   = PAD_W'(in_num);
            pre_rem    = '0;
            vld_src[s] = in_valid;
         end else begin
            pre_work   = work_ff[s-1];
            pre_rem    = rem_ff[s-1];
            vld_src[s] = vld_ff[s-1];
         end
         {work_in[s], rem_in[s]} = div_step(pre_work, pre_rem);
      end
   end

   // a stage takes new data when empty or when it moves on
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_src[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (rdy[s] && vld_src[s]) begin
            work_ff[s] <= work_in[s];
            rem_ff[s]  <= rem_in[s];
            if (s == 0) begin
               side_ff[s] <= in_side;
            end else begin
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[STAGES-1];
   assign out_quo   = work_ff[STAGES-1][WIDTH-1:0];
   assign out_rem   = rem_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_rem < REM_W'(DIVISOR)))
      else $error("divider remainder not below divisor");

   a_first_load: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> vld_ff[0])
      else $error("accepted request missing from first divider stage");
`endif

endmodule

### src/ttd_digits.sv
module ttd_digits
   import ttd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [HOUR_REM_W-1:0]   in_hours,
   input  logic [MINUTE_REM_W-1:0] in_minutes,
   input  logic [TENTHS_REM_W-1:0] in_tenths,
   output logic                    out_valid,
   input  logic                    out_ready,
   output digits_type              out_digits
);

   // first split: low digits and tens counts
   logic [DIV10_OUT_W-1:0] hq_ff, hq_in;
   logic [DIGIT_W-1:0]     h0_ff, h0_in;
   logic [DIGIT_W-1:0]     m1_ff, m1_in;
   logic [DIGIT_W-1:0]     m0_ff, m0_in;
   logic [DIV10_OUT_W-1:0] rq_ff, rq_in;
   logic [DIGIT_W-1:0]     t_ff, t_in;
   logic                   a_vld_ff;
   logic [DIV10_OUT_W-1:0] mq;

   // second split: hundreds and tens of hours, tens and units of seconds
   digits_type             dig_ff, dig_in;
   logic                   b_vld_ff;
   logic [DIV10_OUT_W-1:0] h2q;
   logic [DIV10_OUT_W-1:0] s1q;

   logic rdy_a;
   logic rdy_b;

   assign rdy_b    = !b_vld_ff || out_ready;
   assign rdy_a    = !a_vld_ff || rdy_b;
   assign in_ready = rdy_a;

   // stage a arithmetic
   always_comb begin
      hq_in = div10(DIV10_IN_W'(in_hours));
      h0_in = rem10(DIV10_IN_W'(in_hours), hq_in);
      mq    = div10(DIV10_IN_W'(in_minutes));
      m1_in = mq[DIGIT_W-1:0];
      m0_in = rem10(DIV10_IN_W'(in_minutes), mq);
      rq_in = div10(DIV10_IN_W'(in_tenths));
      t_in  = rem10(DIV10_IN_W'(in_tenths), rq_in);
   end

   // stage b arithmetic
   always_comb begin
      h2q       = div10(DIV10_IN_W'(hq_ff));
      s1q       = div10(DIV10_IN_W'(rq_ff));
      dig_in.h2 = h2q[DIGIT_W-1:0];
      dig_in.h1 = rem10(DIV10_IN_W'(hq_ff), h2q);
      dig_in.h0 = h0_ff;
      dig_in.m1 = m1_ff;
      dig_in.m0 = m0_ff;
      dig_in.s1 = s1q[DIGIT_W-1:0];
      dig_in.s0 = rem10(DIV10_IN_W'(rq_ff), s1q);
      dig_in.t  = t_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            a_vld_ff <= in_valid;
         end
         if (rdy_b) begin
            b_vld_ff <= a_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         hq_ff <= hq_in;
         h0_ff <= h0_in;
         m1_ff <= m1_in;
         m0_ff <= m0_in;
         rq_ff <= rq_in;
         t_ff  <= t_in;
      end
      if (rdy_b && a_vld_ff) begin
         dig_ff <= dig_in;
      end
   end

   assign out_valid  = b_vld_ff;
   assign out_digits = dig_ff;

`ifndef SYNTHESIS
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (dig_ff.h2 <= 4'd9 && dig_ff.h1 <= 4'd9 && dig_ff.h0 <= 4'd9 &&
                     dig_ff.m1 <= 4'd5 && dig_ff.m0 <= 4'd9 && dig_ff.s1 <= 4'd5 &&
                     dig_ff.s0 <= 4'd9 && dig_ff.t <= 4'd9))
      else $error("decimal digit out of range");
`endif

endmodule

### src/ttd_ser.sv
module ttd_ser
   import ttd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  digits_type        in_digits,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAR_W-1:0] out_character,
   output logic              out_last
);

   localparam int CNT_W = $clog2(RESULT_COUNT + 1);

   logic [CHAR_W-1:0] chr_ff [RESULT_COUNT];
   logic [CHAR_W-1:0] chr_in [RESULT_COUNT];
   logic [CNT_W-1:0]  cnt_ff;
   logic              load;
   logic              shift;

   // digit, or blank while only leading zeros have been seen and fill_zero is clear
   function automatic logic [CHAR_W-1:0] show(input logic [DIGIT_W-1:0] d,
                                              input logic seen,
                                              input logic fill_zero);
      if (d != '0 || seen || fill_zero) begin
         return ASCII_ZERO + CHAR_W'(d);
      end else begin
         return ASCII_SPACE;
      end
   endfunction

   // build the line: HHH:MM:SS.T and newline
   always_comb begin
      logic seen;
      seen       = 1'b0;
      chr_in[0]  = show(in_digits.h2, seen, 1'b0);
      seen       = seen || (in_digits.h2 != '0);
      chr_in[1]  = show(in_digits.h1, seen, 1'b0);
      seen       = seen || (in_digits.h1 != '0);
      chr_in[2]  = show(in_digits.h0, seen, 1'b0);
      seen       = seen || (in_digits.h0 != '0);
      chr_in[3]  = seen ? ASCII_COLON : ASCII_SPACE;
      chr_in[4]  = show(in_digits.m1, seen, 1'b0);
      seen       = seen || (in_digits.m1 != '0);
      chr_in[5]  = show(in_digits.m0, seen, 1'b0);
      seen       = seen || (in_digits.m0 != '0);
      chr_in[6]  = seen ? ASCII_COLON : ASCII_SPACE;
      chr_in[7]  = show(in_digits.s1, seen, 1'b0);
      chr_in[8]  = show(in_digits.s0, seen, 1'b1);
      chr_in[9]  = ASCII_PERIOD;
      chr_in[10] = show(in_digits.t, seen, 1'b1);
      chr_in[11] = ASCII_NEWLINE;
   end

   // next request loads as the newline of the current one leaves
   assign out_valid = (cnt_ff != '0);
   assign out_last  = (cnt_ff == CNT_W'(1));
   assign in_ready  = !out_valid || (out_last && out_ready);
   assign load      = in_valid && in_ready;
   assign shift     = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= CNT_W'(RESULT_COUNT);
      end else if (shift) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < RESULT_COUNT; k++) begin
            chr_ff[k] <= chr_in[k];
         end
      end else if (shift) begin
         for (int k = 0; k < RESULT_COUNT - 1; k++) begin
            chr_ff[k] <= chr_ff[k+1];
         end
      end
   end

   assign out_character = chr_ff[0];

`ifndef SYNTHESIS
   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_last) |-> (out_character == ASCII_NEWLINE))
      else $error("final character of a line is not a newline");

   a_full_line: assert property (@(posedge clock) disable iff (reset)
      load |=> (cnt_ff == CNT_W'(RESULT_COUNT)))
      else $error("line count not reloaded on request");
`endif

endmodule

### src/tick_count_to_time_display.sv
// channel  direction  fields                        handshake
// req      in         req_ticks[31:0]               req_valid / req_ready
// rsp      out        rsp_character[7:0], rsp_last  rsp_valid / rsp_ready
//
// each request gives twelve characters, one per cycle while rsp_ready is high, so
// the sustained request rate is set by the single character port.
// path from request to first character, W the used width:
// four constant dividers of ceil(W / 4) stages each, two digit stages, one line load.
// reset is synchronous and empties every stage; no request is pending after it.
// a stall on rsp holds the line in the output shift register while stages fill up.
module tick_count_to_time_display
   import ttd_pkg::*;
#(
   parameter int TICKS_PER_TENTH = TICKS_PER_TENTH_DEF,
   parameter int TICK_WIDTH      = TICK_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TICK_PORT_W-1:0] req_ticks,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_W-1:0]      rsp_character,
   output logic                   rsp_last
);

   localparam int TW  = (TICK_WIDTH < TICK_PORT_W) ? TICK_WIDTH : TICK_PORT_W;
   localparam int TPT = (TICKS_PER_TENTH == 0) ? 1 : TICKS_PER_TENTH;

   logic                    tn_valid, tn_ready;
   logic [TW-1:0]           tn_quo;
   logic                    mn_valid, mn_ready;
   logic [TW-1:0]           mn_quo;
   logic [TENTHS_REM_W-1:0] mn_rem;
   logic                    hr_valid, hr_ready;
   logic [TW-1:0]           hr_quo;
   logic [MINUTE_REM_W-1:0] hr_rem;
   logic [TENTHS_REM_W-1:0] hr_side;
   logic                    wr_valid, wr_ready;
   logic [HOUR_REM_W-1:0]   wr_rem;
   logic [MINUTE_REM_W+TENTHS_REM_W-1:0] wr_side;
   logic                    dg_valid, dg_ready;
   digits_type              dg_digits;

   // ticks to tenths, sub-tenth remainder dropped
   ttd_cdiv #(
      .WIDTH   (TW),
      .DIVISOR (TPT),
      .SIDE_W  (1)
   ) u_tenths (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_num    (req_ticks[TW-1:0]),
      .in_side   (1'b0),
      .out_valid (tn_valid),
      .out_ready (tn_ready),
      .out_quo   (tn_quo),
      .out_rem   (),
      .out_side  ()
   );

   // tenths to minutes, tenths within the minute kept
   ttd_cdiv #(
      .WIDTH   (TW),
      .DIVISOR (TENTHS_PER_MINUTE),
      .SIDE_W  (1)
   ) u_minutes (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tn_valid),
      .in_ready  (tn_ready),
      .in_num    (tn_quo),
      .in_side   (1'b0),
      .out_valid (mn_valid),
      .out_ready (mn_ready),
      .out_quo   (mn_quo),
      .out_rem   (mn_rem),
      .out_side  ()
   );

   // minutes to hours
   ttd_cdiv #(
      .WIDTH   (TW),
      .DIVISOR (MINUTES_PER_HOUR),
      .SIDE_W  (TENTHS_REM_W)
   ) u_hours (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mn_valid),
      .in_ready  (mn_ready),
      .in_num    (mn_quo),
      .in_side   (mn_rem),
      .out_valid (hr_valid),
      .out_ready (hr_ready),
      .out_quo   (hr_quo),
      .out_rem   (hr_rem),
      .out_side  (hr_side)
   );

   // hours wrap past 999
   ttd_cdiv #(
      .WIDTH   (TW),
      .DIVISOR (HOUR_WRAP),
      .SIDE_W  (MINUTE_REM_W + TENTHS_REM_W)
   ) u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hr_valid),
      .in_ready  (hr_ready),
      .in_num    (hr_quo),
      .in_side   ({hr_rem, hr_side}),
      .out_valid (wr_valid),
      .out_ready (wr_ready),
      .out_quo   (),
      .out_rem   (wr_rem),
      .out_side  (wr_side)
   );

   // decimal digits
   ttd_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wr_valid),
      .in_ready   (wr_ready),
      .in_hours   (wr_rem),
      .in_minutes (wr_side[MINUTE_REM_W+TENTHS_REM_W-1:TENTHS_REM_W]),
      .in_tenths  (wr_side[TENTHS_REM_W-1:0]),
      .out_valid  (dg_valid),
      .out_ready  (dg_ready),
      .out_digits (dg_digits)
   );

   // characters out, one per cycle while rsp_ready is high
   ttd_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (dg_valid),
      .in_ready      (dg_ready),
      .in_digits     (dg_digits),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_character (rsp_character),
      .out_last      (rsp_last)
   );

endmodule

### tb/tick_count_to_time_display_test.sv
`timescale 1ns / 1ps

module tick_count_to_time_display_test;
   import ttd_pkg::*;

   // tenth divisor as the block uses it, a zero divisor counts as one
   localparam int unsigned TENTH_TICKS =
      (TICKS_PER_TENTH_DEF == 0) ? 1 : TICKS_PER_TENTH_DEF;
   localparam longint unsigned TICKS_PER_HOUR = longint'(TENTH_TICKS) * 36000;
   localparam int DISPLAY_POSITIONS = 9;
   localparam int RANDOM_REQUESTS   = 350;
   localparam int PRESSURE_AT       = 120;
   localparam int PRESSURE_BURST    = 40;
   localparam int DRAIN_AT          = 250;
   localparam int HOLD_OFF_CYCLES   = 300;
   localparam int SETTLE_CYCLES     = 4 * ((TICK_WIDTH_DEF + 3) / 4) + 3 + 20;
   localparam int WATCHDOG_LIMIT    = 2000;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   // expected characters of every accepted request, oldest first
   class display_scoreboard;
      logic [CHAR_W-1:0] char_q[$];
      bit                last_q[$];
      int unsigned       errors;
      int unsigned       requests;
      int unsigned       checked;
      int unsigned       wrapped;

      // split the count by mixed radix and queue the twelve characters
      function void note_request(logic [TICK_PORT_W-1:0] ticks);
         longint unsigned rest;
         longint unsigned divisor;
         int              digit [DISPLAY_POSITIONS];
         bit              seen;
         rest = longint'(ticks);
         if (TICK_WIDTH_DEF < 64)
            rest = rest & ((64'd1 << TICK_WIDTH_DEF) - 64'd1);
         if (rest / TICKS_PER_HOUR >= HOUR_WRAP)
            wrapped++;
         requests++;
         for (int i = 0; i < DISPLAY_POSITIONS; i++) begin
            if (i == 0)
               divisor = TENTH_TICKS;
            else if (i == 3 || i == 5)
               divisor = 6;
            else
               divisor = 10;
            digit[i] = int'(rest % divisor);
            rest = rest / divisor;
         end
         seen = 1'b0;
         // hours down to tenths; leading zeros blank except units of seconds and tenths
         for (int i = DISPLAY_POSITIONS - 1; i > 0; i--) begin
            if (digit[i] != 0)
               char_q.push_back(ASCII_ZERO + CHAR_W'(digit[i]));
            else if (seen || i < 3)
               char_q.push_back(ASCII_ZERO);
            else
               char_q.push_back(ASCII_SPACE);
            last_q.push_back(1'b0);
            if (digit[i] != 0)
               seen = 1'b1;
            if (i == 2) begin
               char_q.push_back(ASCII_PERIOD);
               last_q.push_back(1'b0);
            end else if (i == 4 || i == 6) begin
               char_q.push_back(seen ? ASCII_COLON : ASCII_SPACE);
               last_q.push_back(1'b0);
            end
         end
         char_q.push_back(ASCII_NEWLINE);
         last_q.push_back(1'b1);
      endfunction

      // compare one character against the oldest expectation
      function void check_char(logic [CHAR_W-1:0] character, logic last);
         logic [CHAR_W-1:0] want_char;
         bit                want_last;
         if (char_q.size() == 0) begin
            $error("unexpected character 0x%02h with nothing pending", character);
            errors++;
            return;
         end
         want_char = char_q.pop_front();
         want_last = last_q.pop_front();
         checked++;
         if (character !== want_char) begin
            $error("character: expected 0x%02h, actual 0x%02h", want_char, character);
            errors++;
         end
         if (last !== want_last) begin
            $error("last: expected %0b, actual %0b", want_last, last);
            errors++;
         end
      endfunction

      function int pending();
         return char_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [TICK_PORT_W-1:0] req_ticks = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAR_W-1:0]      rsp_character;
   logic                   rsp_last;

   display_scoreboard sb;
   int unsigned       hold_off_asks = 0;
   int unsigned       hold_off_done = 0;
   int unsigned       stall_left = 0;
   int unsigned       mode_left = 0;
   int unsigned       rx_phase = 0;
   rx_mode_type       rx_mode = RX_OPEN;
   int unsigned       quiet_cycles = 0;

   tick_count_to_time_display #(
      .TICKS_PER_TENTH(TICKS_PER_TENTH_DEF),
      .TICK_WIDTH     (TICK_WIDTH_DEF)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_ticks    (req_ticks),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_ticks);
         if (rsp_valid && rsp_ready)
            sb.check_char(rsp_character, rsp_last);
      end
   end

   // receiver: long hold-off on request, else a changing stall pattern
   always @(posedge clock) begin
      rx_phase <= rx_phase + 1;
      if (hold_off_asks != hold_off_done) begin
         hold_off_done <= hold_off_asks;
         stall_left    <= HOLD_OFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   <= rx_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_OPEN:     rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_ready <= (rx_phase % 5) > 1;
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // watchdog on cycles with no accepted request or character
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d characters still pending",
                  quiet_cycles, sb.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   // offer one request and hold it until accepted
   task automatic drive_request(input logic [TICK_PORT_W-1:0] ticks);
      req_valid <= 1'b1;
      req_ticks <= ticks;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // mix of uniform counts, small counts, counts near digit boundaries and near the maximum
   function automatic logic [TICK_PORT_W-1:0] pick_ticks();
      longint unsigned unit;
      int              span;
      int              offset;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3:       return $urandom_range(0, 2 * 15000);
         4:       return $urandom_range(0, 900000);
         5:       return $urandom_range(0, 899999999);
         6, 8: begin
            unit = TENTH_TICKS;
            span = $urandom_range(0, 9);
            for (int p = 1; p < span; p++)
               unit = unit * ((p == 3 || p == 5) ? 6 : 10);
            offset = int'($urandom_range(0, 6)) - 3;
            return TICK_PORT_W'(longint'(unit * $urandom_range(1, 5)) + offset);
         end
         7:       return $urandom >> $urandom_range(0, 31);
         default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
   endfunction

   initial begin
      int sent;
      int burst;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: blanking, carries, hour limit and wrap, field extremes
      drive_request(32'd0);
      drive_request(32'd24);
      drive_request(32'd25);
      drive_request(32'd249);
      drive_request(32'd250);
      drive_request(32'd2475);
      drive_request(32'd2500);
      drive_request(32'd14999);
      drive_request(32'd15000);
      drive_request(32'd150000);
      drive_request(32'd899999);
      drive_request(32'd900000);
      drive_request(32'd9000000);
      drive_request(32'd90000000);
      drive_request(32'd899999999);
      drive_request(32'd900000000);
      drive_request(32'd900000025);
      drive_request(32'h5555_5555);
      drive_request(32'hAAAA_AAAA);
      drive_request(32'h8000_0000);
      drive_request(32'hFFFF_FFFF);
      idle_sender(0);
      wait_drained();

      // random bursts with gaps, one long receiver hold-off and at least one full drain
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (sent >= PRESSURE_AT && sent < PRESSURE_AT + PRESSURE_BURST) begin
            hold_off_asks <= hold_off_asks + 1;
            repeat (PRESSURE_BURST) begin
               drive_request(pick_ticks());
               sent++;
            end
         end
         if (sent >= DRAIN_AT && sent < DRAIN_AT + 13) begin
            idle_sender(0);
            wait_drained();
         end
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            drive_request(pick_ticks());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 20));
      end
      idle_sender(0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d tick counts (%0d past the hour wrap), %0d characters checked",
               sb.requests, sb.wrapped, sb.checked);
      $display("including blanked leading fields, full hours and long output stalls");
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
src/ttd_pkg.sv
src/ttd_cdiv.sv
src/ttd_digits.sv
src/ttd_ser.sv
src/tick_count_to_time_display.sv
tb/tick_count_to_time_display_test.sv
